### hw/rtl/mwtg_pkg.sv
// Package for the multi-waveform tone generator: waveform constants,
// widths and the sine sample function used to build the phase table.
// No dependencies.
package mwtg_pkg;

    localparam int unsigned DAC_W       = 12;
    localparam int unsigned TEMP_W      = 11;
    localparam int unsigned TPV_W       = 16;
    localparam int unsigned TSAW_W      = 13;
    localparam int unsigned QUOT_W      = 12;
    localparam int unsigned DIV_STEPS   = 16;

    localparam int unsigned SINE_STEPS_DEF = 16;

    localparam logic [DAC_W-1:0]  TRI_STEP = 12'd511;
    localparam logic [DAC_W-1:0]  TRI_TOP  = 12'd4088;
    localparam logic [DAC_W-1:0]  SAW_STEP = 12'd255;
    localparam logic [DAC_W-1:0]  SAW_TOP  = 12'd4080;
    localparam logic [DAC_W-1:0]  DAC_MAX  = 12'd4095;
    localparam logic [15:0]       TEMP_NUM = 16'd65520;
    localparam logic [TEMP_W-1:0] TEMP_MIN = 11'd16;
    localparam logic [TPV_W-1:0]  TPV_RESET = 16'd3500;

    localparam logic [63:0] Q30_ONE     = 64'd1073741824;
    localparam logic [63:0] PI_HALF_Q30 = 64'd1686629713;

    typedef enum logic [1:0] {
        VOICE_SINE = 2'd0,
        VOICE_SAW  = 2'd1,
        VOICE_TRI  = 2'd2
    } t_voice;

    typedef enum logic [1:0] {
        MODE_BOOT  = 2'd0,
        MODE_CYCLE = 2'd1,
        MODE_TEMP  = 2'd2
    } t_mode;

    // One series step: divide by the next factorial ratio.
    function automatic logic [63:0] fact_step(input logic [63:0] p, input logic odd,
                                              input logic [2:0] k);
        logic [63:0] q;
        case ({odd, k})
            4'b1_001: q = p / 64'd6;
            4'b1_010: q = p / 64'd20;
            4'b1_011: q = p / 64'd42;
            4'b1_100: q = p / 64'd72;
            4'b1_101: q = p / 64'd110;
            4'b1_110: q = p / 64'd156;
            4'b0_001: q = p / 64'd2;
            4'b0_010: q = p / 64'd12;
            4'b0_011: q = p / 64'd30;
            4'b0_100: q = p / 64'd56;
            4'b0_101: q = p / 64'd90;
            4'b0_110: q = p / 64'd132;
            default:  q = '0;
        endcase
        return q;
    endfunction

    // Taylor series in Q30: sin to x^13 when odd, else cos to x^12.
    function automatic logic signed [63:0] series_q30(input logic [63:0] x, input logic odd);
        logic [63:0]        x2;
        logic [63:0]        term;
        logic signed [63:0] sum;
        x2   = (x * x) >> 30;
        term = odd ? x : Q30_ONE;
        sum  = $signed(term);
        for (int k = 1; k <= 6; k++) begin
            term = fact_step((term * x2) >> 30, odd, 3'(k));
            if ((k % 2) == 1) begin
                sum = sum - $signed(term);
            end else begin
                sum = sum + $signed(term);
            end
        end
        return sum;
    endfunction

    // DAC code for a quadrant and an in-quadrant angle x (Q30 radians).
    function automatic logic [DAC_W-1:0] sine_sample(input logic [63:0] x,
                                                    input logic [1:0] quad);
        logic signed [63:0] s;
        logic [63:0]        v;
        s = series_q30(x, !quad[0]);
        if (quad[1]) begin
            s = -s;
        end
        if (s > $signed(Q30_ONE)) begin
            s = $signed(Q30_ONE);
        end
        if (s < -$signed(Q30_ONE)) begin
            s = -$signed(Q30_ONE);
        end
        v = ((64'(s) + Q30_ONE) * 64'd2048) >> 30;
        return (v > 64'(DAC_MAX)) ? DAC_MAX : v[DAC_W-1:0];
    endfunction

endpackage

### hw/rtl/multi_waveform_tone_generator_core.sv
// Tone generator core: triangle, saw, sine and temperature saw voices,
// with a bit-serial divider for the temperature step.
// Depends on mwtg_pkg.
//
//  channel | signals                                   | direction
//  --------+-------------------------------------------+----------
//  in      | i_in_valid, o_in_stall, i_req_type,       | request in
//          | i_temperature                             |
//  out     | o_out_valid, i_out_stall, o_dac_value,    | result out
//          | o_led_on, o_mode_code                     |
//  cfg     | i_cfg_we, i_cfg_data (ticks_per_voice)    | write only
//
// A tick request runs through the restoring divider (one quotient bit per cycle
// through one shared subtractor), then the update and the output state; a
// press request skips the divider and goes to the update, then the output state.
// The next request is taken once the sequencer is back in idle, even while
// the previous result still sits in the output register.
// Synchronous active-low reset; the output stage holds while i_out_stall.
module multi_waveform_tone_generator_core
    import mwtg_pkg::*;
#(
    parameter int unsigned SINE_STEPS = SINE_STEPS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic              i_req_type,
    input  logic [TEMP_W-1:0] i_temperature,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic [DAC_W-1:0]  o_dac_value,
    output logic              o_led_on,
    output logic [1:0]        o_mode_code,
    input  logic              i_cfg_we,
    input  logic [TPV_W-1:0]  i_cfg_data
);

    localparam int unsigned PH_W = $clog2(SINE_STEPS);
    localparam logic [PH_W-1:0] PH_LAST = PH_W'(SINE_STEPS - 1);

    typedef logic [SINE_STEPS-1:0][DAC_W-1:0] t_sine_tab;

    function automatic t_sine_tab build_sine_tab();
        t_sine_tab   tab;
        logic [63:0] quad;
        logic [63:0] rem;
        logic [63:0] x;
        for (int i = 0; i < SINE_STEPS; i++) begin
            quad   = 64'((4 * i) / SINE_STEPS);
            rem    = 64'((4 * i) % SINE_STEPS);
            x      = (PI_HALF_Q30 * rem) / SINE_STEPS;
            tab[i] = sine_sample(x, quad[1:0]);
        end
        return tab;
    endfunction

    localparam t_sine_tab SINE_TAB = build_sine_tab();

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_UPD,
        S_OUT
    } t_state;

    t_state              r_state;
    logic                r_is_press;
    logic [TPV_W-1:0]    r_ticks_per_voice;

    logic [DAC_W-1:0]    r_tri_level;
    logic                r_tri_falling;
    logic [DAC_W-1:0]    r_saw_level;
    logic [PH_W-1:0]     r_sine_phase;
    logic [TSAW_W-1:0]   r_temp_saw_level;
    logic [TPV_W-1:0]    r_tick_count;
    t_voice              r_voice_index;
    logic                r_booted_idle;
    logic                r_temp_mode;

    // divider
    logic [TEMP_W-1:0]   r_divisor;
    logic [TEMP_W-1:0]   r_rem;
    logic [QUOT_W-1:0]   r_quot;
    logic [3:0]          r_div_cnt;

    logic [TEMP_W:0]     n_trial;
    logic                n_qbit;
    logic [TEMP_W-1:0]   n_rem;
    logic [TPV_W-1:0]    n_tick;
    logic [DAC_W-1:0]    n_dac;
    t_mode               n_mode;

    logic                in_acc;

    assign o_in_stall = (r_state != S_IDLE);
    assign in_acc     = i_in_valid && !o_in_stall;

    // one restoring step: dividend bits enter MSB first
    always_comb begin
        n_trial = {r_rem, TEMP_NUM[~r_div_cnt]};
        n_qbit  = (n_trial >= {1'b0, r_divisor});
        n_rem   = n_qbit ? TEMP_W'(n_trial - {1'b0, r_divisor}) : n_trial[TEMP_W-1:0];
    end

    assign n_tick = r_tick_count + TPV_W'(1);

    always_comb begin
        if (r_booted_idle) begin
            n_dac  = r_saw_level;
            n_mode = MODE_BOOT;
        end else if (!r_temp_mode) begin
            n_mode = MODE_CYCLE;
            unique case (r_voice_index)
                VOICE_SAW: n_dac = r_saw_level;
                VOICE_TRI: n_dac = r_tri_level;
                default:   n_dac = SINE_TAB[r_sine_phase];
            endcase
        end else begin
            n_mode = MODE_TEMP;
            n_dac  = (r_temp_saw_level > TSAW_W'(DAC_MAX)) ? DAC_MAX
                                                           : r_temp_saw_level[DAC_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state           <= S_IDLE;
            r_is_press        <= 1'b0;
            r_ticks_per_voice <= TPV_RESET;
            r_tri_level       <= '0;
            r_tri_falling     <= 1'b0;
            r_saw_level       <= '0;
            r_sine_phase      <= '0;
            r_temp_saw_level  <= '0;
            r_tick_count      <= '0;
            r_voice_index     <= VOICE_SINE;
            r_booted_idle     <= 1'b1;
            r_temp_mode       <= 1'b1;
            r_div_cnt         <= '0;
            o_out_valid       <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_ticks_per_voice <= i_cfg_data;
            end
            // in the output step the slot is refilled below
            if (o_out_valid && !i_out_stall && r_state != S_OUT) begin
                o_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_is_press <= i_req_type;
                        r_divisor  <= (i_temperature < TEMP_MIN) ? TEMP_MIN : i_temperature;
                        r_rem      <= '0;
                        r_quot     <= '0;
                        r_div_cnt  <= '0;
                        r_state    <= i_req_type ? S_UPD : S_DIV;
                    end
                end
                S_DIV: begin
                    r_rem     <= n_rem;
                    r_quot    <= {r_quot[QUOT_W-2:0], n_qbit};
                    r_div_cnt <= r_div_cnt + 4'd1;
                    if (r_div_cnt == 4'(DIV_STEPS - 1)) begin
                        r_state <= S_UPD;
                    end
                end
                S_UPD: begin
                    if (r_is_press) begin
                        r_temp_mode   <= !r_temp_mode;
                        r_booted_idle <= 1'b0;
                    end else begin
                        if (!r_tri_falling) begin
                            if (r_tri_level < TRI_TOP) begin
                                r_tri_level <= r_tri_level + TRI_STEP;
                            end else begin
                                r_tri_falling <= 1'b1;
                            end
                        end else begin
                            if (r_tri_level != '0) begin
                                r_tri_level <= r_tri_level - TRI_STEP;
                            end else begin
                                r_tri_falling <= 1'b0;
                            end
                        end
                        r_saw_level  <= (r_saw_level < SAW_TOP) ? r_saw_level + SAW_STEP
                                                                : '0;
                        r_sine_phase <= (r_sine_phase == PH_LAST) ? '0
                                                                  : r_sine_phase + PH_W'(1);
                        r_temp_saw_level <= (r_temp_saw_level < TSAW_W'(DAC_MAX))
                                          ? r_temp_saw_level + TSAW_W'(r_quot) : '0;
                        if (n_tick == r_ticks_per_voice) begin
                            r_tick_count  <= '0;
                            r_voice_index <= (r_voice_index == VOICE_SINE) ? VOICE_SAW
                                           : (r_voice_index == VOICE_SAW)  ? VOICE_TRI
                                           : VOICE_SINE;
                        end else begin
                            r_tick_count <= n_tick;
                        end
                    end
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    // wait for a free output slot
                    if (!o_out_valid || !i_out_stall) begin
                        o_out_valid <= 1'b1;
                        o_dac_value <= n_dac;
                        o_led_on    <= (n_mode == MODE_TEMP);
                        o_mode_code <= n_mode;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

`ifndef SYNTHESIS
    a_tri_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_tri_level <= TRI_TOP)
        else $error("triangle level out of range");

    a_voice_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_voice_index == VOICE_SINE || r_voice_index == VOICE_SAW
        || r_voice_index == VOICE_TRI)
        else $error("voice index took the unused code");

    a_press_path: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && i_req_type |=> r_state == S_UPD)
        else $error("press request did not skip the divider");

    a_tick_path: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && !i_req_type |=> r_state == S_DIV && r_div_cnt == 4'd0)
        else $error("tick request did not start the divider");

    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_state) == S_OUT)
        else $error("result appeared outside the output step");

    a_boot_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_mode_code == MODE_BOOT |-> !o_led_on)
        else $error("boot mode result with the LED on");
`endif

endmodule
